[rtl/core/tuu_pkg.sv]
// Shared types, constants and mapping functions of the Turkish UTF-8 uppercase block.
// No dependencies; every other file of the block uses this package.
package tuu_pkg;

  // Byte codes used in classification and mapping
  localparam logic [7:0] ByteTerm   = 8'h00;
  localparam logic [7:0] ByteAsciiI = 8'h49;
  localparam logic [7:0] ByteLowA   = 8'h61;
  localparam logic [7:0] ByteLowI   = 8'h69;
  localparam logic [7:0] ByteLowZ   = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;
  localparam logic [7:0] LeadC4     = 8'hC4;
  localparam logic [7:0] ContB0     = 8'hB0;
  localparam logic [7:0] ContB1     = 8'hB1;
  localparam logic [7:0] Lead4Mask  = 8'hF8;

  localparam logic [15:0] BufSizeReset = 16'd256;

  // One group of result bytes produced by one input word
  typedef struct packed {
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
    logic [2:0]      cnt;    // 1..4 bytes in use
    logic            last;   // final byte of the group is the terminator
  } grp_t;

  // Sequence length from the lead byte; 1 for anything that is no lead byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Two-byte lowercase letters and their uppercase forms
  function automatic logic [15:0] map_pair(input logic [15:0] p);
    logic [15:0] r;
    unique case (p)
      16'hC3A7: r = 16'hC387;
      16'hC3B6: r = 16'hC396;
      16'hC3BC: r = 16'hC39C;
      16'hC49F: r = 16'hC49E;
      16'hC59F: r = 16'hC59E;
      16'hC3A2: r = 16'hC382;
      16'hC3AE: r = 16'hC38E;
      16'hC3BB: r = 16'hC39B;
      default:  r = p;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/tuu_front.sv]
// Front end: accepts input words, collects multi-byte sequences, maps characters,
// applies the capacity rule and hands byte groups to the queue. Uses tuu_pkg.
module tuu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic [7:0]         in_byte_i,
  input  logic [15:0]        buffer_size_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tuu_pkg::grp_t      q_grp_o
);

  logic [2:0][7:0] pending_q, pending_d;
  logic [2:0]      exp_len_q, exp_len_d;
  logic [1:0]      coll_q, coll_d;
  logic [15:0]     written_q, written_d;
  logic            stopped_q, stopped_d;

  logic            accept;
  logic            is_term;
  logic            term_emit;
  logic [3:0][7:0] cbytes;
  logic [2:0]      ck;
  logic            fits;
  logic [16:0]     sum;
  logic [2:0]      n_out;
  logic [2:0]      len;
  logic [15:0]     pair;
  logic [7:0]      up;

  assign accept  = push && !q_full_i;
  assign is_term = (in_byte_i == tuu_pkg::ByteTerm);
  assign len     = tuu_pkg::lead_len(in_byte_i);
  assign pair    = tuu_pkg::map_pair({pending_q[0], in_byte_i});
  assign up      = (in_byte_i >= tuu_pkg::ByteLowA && in_byte_i <= tuu_pkg::ByteLowZ) ?
                   (in_byte_i - tuu_pkg::CaseOffset) : in_byte_i;

  // Classify the word: character bytes to write and collection state
  always_comb begin
    cbytes    = '0;
    ck        = 3'd0;
    pending_d = pending_q;
    exp_len_d = exp_len_q;
    coll_d    = coll_q;
    if (is_term) begin
      if (exp_len_q != 3'd0) begin
        cbytes[2:0] = pending_q;
        ck          = {1'b0, coll_q};
      end
      exp_len_d = 3'd0;
      coll_d    = 2'd0;
    end else if (exp_len_q == 3'd0) begin
      if (!in_byte_i[7]) begin
        if (in_byte_i == tuu_pkg::ByteLowI) begin
          cbytes[0] = tuu_pkg::LeadC4;
          cbytes[1] = tuu_pkg::ContB0;
          ck        = 3'd2;
        end else begin
          cbytes[0] = up;
          ck        = 3'd1;
        end
      end else if (len == 3'd1) begin
        cbytes[0] = in_byte_i;
        ck        = 3'd1;
      end else begin
        pending_d[0] = in_byte_i;
        coll_d       = 2'd1;
        exp_len_d    = len;
      end
    end else if (({1'b0, coll_q} + 3'd1) < exp_len_q && coll_q != 2'd3) begin
      pending_d[coll_q] = in_byte_i;
      coll_d            = coll_q + 2'd1;
    end else begin
      exp_len_d = 3'd0;
      coll_d    = 2'd0;
      if (exp_len_q == 3'd2) begin
        if (pending_q[0] == tuu_pkg::LeadC4 && in_byte_i == tuu_pkg::ContB1) begin
          cbytes[0] = tuu_pkg::ByteAsciiI;
          ck        = 3'd1;
        end else begin
          cbytes[0] = pair[15:8];
          cbytes[1] = pair[7:0];
          ck        = 3'd2;
        end
      end else begin
        cbytes[2:0]     = pending_q;
        cbytes[coll_q]  = in_byte_i;
        ck              = {1'b0, coll_q} + 3'd1;
      end
    end
  end

  // Apply the capacity rule
  assign sum       = {1'b0, written_q} + 17'(ck);
  assign fits      = !stopped_q && (ck != 3'd0) && (sum < {1'b0, buffer_size_i});
  assign term_emit = is_term && (buffer_size_i != 16'd0);
  assign n_out     = fits ? ck : 3'd0;

  // Build the byte group for the queue
  always_comb begin
    q_grp_o.bytes = cbytes;
    for (int i = 0; i < 4; i++) begin
      if (term_emit && n_out == 3'(i)) begin
        q_grp_o.bytes[i] = tuu_pkg::ByteTerm;
      end
    end
    q_grp_o.cnt  = n_out + {2'b00, term_emit};
    q_grp_o.last = term_emit;
  end

  assign q_push_o = accept && (q_grp_o.cnt != 3'd0);

  // Next string counters
  always_comb begin
    written_d = written_q;
    stopped_d = stopped_q;
    if (is_term) begin
      written_d = '0;
      stopped_d = 1'b0;
    end else if (fits) begin
      written_d = sum[15:0];
    end else if (ck != 3'd0) begin
      stopped_d = 1'b1;
    end
  end

  // Hold string state, advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      coll_q    <= '0;
      written_q <= '0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      exp_len_q <= exp_len_d;
      coll_q    <= coll_d;
      written_q <= written_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pending_q <= pending_d;
    end
  end

  a_coll_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_len_q != 3'd0) |-> ({1'b0, coll_q} < exp_len_q && coll_q != 2'd0))
    else $error("front: collected count out of range for sequence");

endmodule

[rtl/core/tuu_queue.sv]
// Short queue of byte groups between front and back end.
// Uses tuu_pkg for the group type.
module tuu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  tuu_pkg::grp_t wr_grp_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output tuu_pkg::grp_t rd_grp_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tuu_pkg::grp_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign rd_grp_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en_i && !wr_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming group
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_grp_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (!full_o || rd_en_i))
    else $error("queue: write into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("queue: read from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue: fill count beyond depth");

endmodule

[rtl/core/tuu_back.sv]
// Back end: splits queued byte groups into single result words and holds the
// output register. Uses tuu_pkg for the group type.
module tuu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tuu_pkg::grp_t q_grp_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load;
  logic       take;
  logic       final_byte;

  assign load       = !valid_q || pop;
  assign take       = load && !q_empty_i;
  assign final_byte = (({1'b0, idx_q} + 3'd1) == q_grp_i.cnt);
  assign q_pop_o    = take && final_byte;

  // Step through the head group one byte per cycle unless the output stalls
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (load) begin
      valid_d = !q_empty_i;
    end
    if (take) begin
      byte_d = q_grp_i.bytes[idx_q];
      last_d = q_grp_i.last && final_byte;
      idx_d  = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty      = !valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

  a_last_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (out_byte_o == tuu_pkg::ByteTerm))
    else $error("back: last flag on a non-terminator word");

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (!q_empty_i && ({1'b0, idx_q} < q_grp_i.cnt)))
    else $error("back: byte index outside head group");

endmodule

[rtl/core/turkish_utf8_uppercase.sv]
// Turkish UTF-8 uppercase: one input word per cycle, one result word per cycle.
// A result passes the queue write and the output register load before reaching
// the output ports. Input rate is one byte per cycle while the group queue has
// room; output rate is one byte per cycle while popped, so strings rich in 'i'
// (one byte in, two out) are paced by the output side.
// Reset clears string state, queue and output; buffer_size returns to 256.
module turkish_utf8_uppercase #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  logic [15:0]   buffer_size_q;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  tuu_pkg::grp_t q_wr_grp;
  tuu_pkg::grp_t q_rd_grp;

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= tuu_pkg::BufSizeReset;
    end else if (cfg_we_i) begin
      buffer_size_q <= cfg_wdata_i;
    end
  end

  assign full = q_full;

  tuu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .in_byte_i    (in_byte_i),
    .buffer_size_i(buffer_size_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_grp_o      (q_wr_grp)
  );

  tuu_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (q_push),
    .wr_grp_i(q_wr_grp),
    .full_o  (q_full),
    .rd_en_i (q_pop),
    .rd_grp_o(q_rd_grp),
    .empty_o (q_empty)
  );

  tuu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_grp_i   (q_rd_grp),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte_o(out_byte_o),
    .last_o    (last_o)
  );

endmodule
